>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the uniquifier top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define PVU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition that must hold at every clock edge outside reset
`define PVU_ASSERT_ALWAYS(label, cond, msg) \
    `PVU_ASSERT(label, cond, msg)

`endif

>>> rtl/core/pvu_pkg.sv
// Types and constants of the provoking-vertex uniquifier
package pvu_pkg;

    localparam int unsigned IDX_W        = 16;
    localparam int unsigned CNT_W        = 17;
    localparam int unsigned IDX_DEPTH    = 1 << IDX_W;
    localparam int unsigned MAX_VERTICES = 65536;

    // first counter value that can no longer be given out as a new index
    localparam logic [CNT_W-1:0] NEW_LIMIT =
        (MAX_VERTICES < IDX_DEPTH) ? CNT_W'(MAX_VERTICES) : CNT_W'(IDX_DEPTH);

    localparam logic [IDX_W-1:0] CLR_LAST = {IDX_W{1'b1}};

    typedef struct packed {
        logic [IDX_W-1:0] vert_first;
        logic [IDX_W-1:0] vert_second;
        logic [IDX_W-1:0] vert_third;
    } t_tri_in;

    typedef struct packed {
        logic [IDX_W-1:0] out_first;
        logic [IDX_W-1:0] out_second;
        logic [IDX_W-1:0] out_third;
        logic             duplicated;
        logic [IDX_W-1:0] copy_source;
        logic             overflow;
    } t_tri_out;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic             bit_val;
    } t_mem_wr;

endpackage

>>> rtl/core/pvu_bitmem.sv
// Used-bit memory: one write port, two registered read ports
module pvu_bitmem
    import pvu_pkg::*;
(
    input  logic             i_clk,
    input  t_mem_wr          i_wr,
    input  logic [IDX_W-1:0] i_rd_addr0,
    input  logic [IDX_W-1:0] i_rd_addr1,
    output logic             o_rd_data0,
    output logic             o_rd_data1
);

    logic r_mem [0:IDX_DEPTH-1];
    logic r_q0;
    logic r_q1;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.bit_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= r_mem[i_rd_addr0];
        r_q1 <= r_mem[i_rd_addr1];
    end

    assign o_rd_data0 = r_q0;
    assign o_rd_data1 = r_q1;

endmodule

>>> rtl/core/provoking_vertex_uniquifier_top.sv
// An accepted triangle passes stage one and stage two; its result then enters the two-entry result queue.
// A new triangle is not taken while the previous one is in stage one, since its three used-bit reads
// share the two read ports of the used-bit memory.
// Reset: synchronous; the new-index counter loads 0, then a clearing pass over all
// 65536 used bits zeroes them while no triangle request is accepted.
// Configuration writes are taken only while no triangle is in flight.
`include "assert_macros.svh"

module provoking_vertex_uniquifier_top
    import pvu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_tri_in          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_tri_out         o_out_data
);

    logic             r_clr_active;
    logic [IDX_W-1:0] r_clr_addr;
    logic [CNT_W-1:0] r_next;
    logic             r_s1_valid;
    t_tri_in          r_s1;
    logic             r_s2_valid;
    t_tri_in          r_s2;
    logic             r_s2_used_c;
    logic             r_s2_used_b;
    logic             r_fwd_valid;
    logic [IDX_W-1:0] r_fwd_addr;
    logic [1:0]       r_pend;
    t_tri_out         r_fifo [0:1];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_fill;

    logic             in_fire;
    logic             out_fire;
    logic             q0;
    logic             q1;
    logic             s1_used_c;
    logic             s1_used_b;
    logic             exhausted;
    logic             mark_en;
    logic [IDX_W-1:0] mark_addr;
    logic             dup_take;
    t_tri_out         n_result;
    t_mem_wr          mem_wr;
    logic [IDX_W-1:0] rd_addr0;

    assign o_cfg_ready = (r_pend == 2'd0);
    assign o_in_ready  = !r_clr_active && !r_s1_valid && (r_pend != 2'd2) && !i_cfg_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = (r_fill != 2'd0);
    assign o_out_data  = r_fifo[r_rptr];
    assign out_fire    = o_out_valid && i_out_ready;

    assign rd_addr0 = r_s1_valid ? r_s1.vert_first : i_in_data.vert_third;

    pvu_bitmem u_bitmem (
        .i_clk      (i_clk),
        .i_wr       (mem_wr),
        .i_rd_addr0 (rd_addr0),
        .i_rd_addr1 (i_in_data.vert_second),
        .o_rd_data0 (q0),
        .o_rd_data1 (q1)
    );

    // forward the mark written at the same edge as the read
    assign s1_used_c = q0 || (r_fwd_valid && (r_fwd_addr == r_s1.vert_third));
    assign s1_used_b = q1 || (r_fwd_valid && (r_fwd_addr == r_s1.vert_second));

    assign exhausted = (r_next >= NEW_LIMIT);

    always_comb begin
        mark_en     = 1'b0;
        mark_addr   = r_s2.vert_third;
        dup_take    = 1'b0;
        n_result.out_first   = r_s2.vert_first;
        n_result.out_second  = r_s2.vert_second;
        n_result.out_third   = r_s2.vert_third;
        n_result.duplicated  = 1'b0;
        n_result.copy_source = '0;
        n_result.overflow    = 1'b0;
        if (!r_s2_used_c) begin
            mark_en = r_s2_valid;
        end else if (!r_s2_used_b) begin
            mark_en   = r_s2_valid;
            mark_addr = r_s2.vert_second;
            n_result.out_first  = r_s2.vert_third;
            n_result.out_second = r_s2.vert_first;
            n_result.out_third  = r_s2.vert_second;
        end else if (!q0) begin
            mark_en   = r_s2_valid;
            mark_addr = r_s2.vert_first;
            n_result.out_first  = r_s2.vert_second;
            n_result.out_second = r_s2.vert_third;
            n_result.out_third  = r_s2.vert_first;
        end else if (exhausted) begin
            n_result.overflow = 1'b1;
        end else begin
            dup_take = r_s2_valid;
            n_result.out_third   = r_next[IDX_W-1:0];
            n_result.duplicated  = 1'b1;
            n_result.copy_source = r_s2.vert_third;
        end
    end

    always_comb begin
        if (r_clr_active) begin
            mem_wr.en      = 1'b1;
            mem_wr.addr    = r_clr_addr;
            mem_wr.bit_val = 1'b0;
        end else begin
            mem_wr.en      = mark_en;
            mem_wr.addr    = mark_addr;
            mem_wr.bit_val = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == CLR_LAST) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_next <= i_cfg_data;
        end else if (dup_take) begin
            r_next <= r_next + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_s1_valid  <= in_fire;
            r_s2_valid  <= r_s1_valid;
            r_fwd_valid <= mark_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= mark_addr;
        if (in_fire) begin
            r_s1 <= i_in_data;
        end
        if (r_s1_valid) begin
            r_s2        <= r_s1;
            r_s2_used_c <= s1_used_c;
            r_s2_used_b <= s1_used_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            case ({in_fire, out_fire})
                2'b10:   r_pend <= r_pend + 1'b1;
                2'b01:   r_pend <= r_pend - 1'b1;
                default: r_pend <= r_pend;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= '0;
        end else begin
            if (r_s2_valid) begin
                r_wptr <= !r_wptr;
            end
            if (out_fire) begin
                r_rptr <= !r_rptr;
            end
            case ({r_s2_valid, out_fire})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_fifo[r_wptr] <= n_result;
        end
    end

    `PVU_ASSERT(a_no_accept_clear, r_clr_active |-> !o_in_ready, "request accepted during clear")
    `PVU_ASSERT(a_s1_to_s2, r_s1_valid |=> r_s2_valid, "stage one item lost")
    `PVU_ASSERT(a_no_push_full, r_s2_valid |-> (r_fill != 2'd2), "result queue overflow")
    `PVU_ASSERT_ALWAYS(a_fill_le_pend, r_fill <= r_pend, "queue holds untracked result")
    `PVU_ASSERT(a_one_write, (r_s2_valid && mark_en) |=> !mark_en, "marks in consecutive cycles")

endmodule

>>> tb/tb_provoking_vertex_uniquifier_top.sv
// Self-checking testbench for the provoking-vertex uniquifier: random and directed triangles
module tb_provoking_vertex_uniquifier_top
    import pvu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_LIMIT = 300000;
    localparam int unsigned WINDOW_SPAN    = 24;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    t_tri_in          i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_tri_out         o_out_data;

    provoking_vertex_uniquifier_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    t_tri_in          tri_pending[$];
    t_tri_out         expected_tris[$];
    bit               vertex_taken[0:IDX_DEPTH-1];
    logic [CNT_W-1:0] fresh_index = '0;
    int unsigned      tris_queued = 0;
    int unsigned      tris_accepted = 0;
    int unsigned      cfg_writes = 0;
    int unsigned      idle_cycles = 0;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_idle_pct = 0;
    logic [IDX_W-1:0] window_base = '0;
    logic             in_taken = 1'b0;
    bit               failed = 1'b0;

    function automatic t_tri_out uniquify(t_tri_in t);
        t_tri_out r;
        r.out_first   = t.vert_first;
        r.out_second  = t.vert_second;
        r.out_third   = t.vert_third;
        r.duplicated  = 1'b0;
        r.copy_source = '0;
        r.overflow    = 1'b0;
        if (!vertex_taken[t.vert_third]) begin
            vertex_taken[t.vert_third] = 1'b1;
        end else if (!vertex_taken[t.vert_second]) begin
            vertex_taken[t.vert_second] = 1'b1;
            r.out_first  = t.vert_third;
            r.out_second = t.vert_first;
            r.out_third  = t.vert_second;
        end else if (!vertex_taken[t.vert_first]) begin
            vertex_taken[t.vert_first] = 1'b1;
            r.out_first  = t.vert_second;
            r.out_second = t.vert_third;
            r.out_third  = t.vert_first;
        end else if (fresh_index >= MAX_VERTICES || fresh_index > CNT_W'(IDX_DEPTH - 1)) begin
            r.overflow = 1'b1;
        end else begin
            r.out_third   = fresh_index[IDX_W-1:0];
            r.duplicated  = 1'b1;
            r.copy_source = t.vert_third;
            fresh_index   = fresh_index + 1'b1;
        end
        return r;
    endfunction

    function automatic void check_field(string fname, logic [IDX_W-1:0] want,
                                        logic [IDX_W-1:0] got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, fname, want, got);
            failed = 1'b1;
        end
    endfunction

    // sample handshakes, check results, predict new requests, track base writes, run the watchdog
    always @(posedge i_clk) begin
        t_tri_out want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (expected_tris.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $realtime, o_out_data);
                    failed = 1'b1;
                end else begin
                    want = expected_tris.pop_front();
                    check_field("out_first", want.out_first, o_out_data.out_first);
                    check_field("out_second", want.out_second, o_out_data.out_second);
                    check_field("out_third", want.out_third, o_out_data.out_third);
                    check_field("duplicated", IDX_W'(want.duplicated),
                                IDX_W'(o_out_data.duplicated));
                    check_field("copy_source", want.copy_source, o_out_data.copy_source);
                    check_field("overflow", IDX_W'(want.overflow),
                                IDX_W'(o_out_data.overflow));
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_tris = {expected_tris, uniquify(i_in_data)};
                tris_accepted++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                fresh_index = i_cfg_data;
                cfg_writes++;
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // request driver and result-side stalls
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (tri_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data  <= tri_pending.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic wait_drained();
        do @(negedge i_clk);
        while (tris_accepted != tris_queued || expected_tris.size() != 0);
    endtask

    task automatic write_base(input logic [CNT_W-1:0] value);
        int unsigned seen;
        seen = cfg_writes;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(negedge i_clk);
        while (cfg_writes == seen);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_tri(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                             input logic [IDX_W-1:0] c);
        t_tri_in t;
        t.vert_first  = a;
        t.vert_second = b;
        t.vert_third  = c;
        tri_pending = {tri_pending, t};
        tris_queued++;
    endtask

    function automatic logic [IDX_W-1:0] pick_vertex();
        if ($urandom_range(99) < 20)
            return IDX_W'($urandom_range(IDX_DEPTH - 1));
        return window_base + IDX_W'($urandom_range(WINDOW_SPAN - 1));
    endfunction

    task automatic run_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 64 == 0)
                window_base = IDX_W'($urandom_range(IDX_DEPTH - 1));
            // hold off until the block has emptied
            if (i == count / 2)
                wait_drained();
            queue_tri(pick_vertex(), pick_vertex(), pick_vertex());
        end
        wait_drained();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 11;
        recv_idle_pct = 76;
        write_base(CNT_W'(65534));
        queue_tri(16'h0000, 16'h0000, 16'h0000);
        queue_tri(16'h0000, 16'h0000, 16'h0000);
        queue_tri(16'h0000, 16'h0000, 16'h0000);
        queue_tri(16'h0000, 16'h0000, 16'h0000);
        queue_tri(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_tri(16'h0001, 16'h0002, 16'hFFFF);
        queue_tri(16'h0001, 16'h0002, 16'hFFFF);
        queue_tri(16'h0001, 16'h0002, 16'hFFFF);
        queue_tri(16'hAAAA, 16'h5555, 16'hFFFF);
        queue_tri(16'h5555, 16'hAAAA, 16'h1234);
        queue_tri(16'h1234, 16'h1234, 16'h1234);
        queue_tri(16'h0007, 16'h0008, 16'h0007);
        queue_tri(16'h0007, 16'h0008, 16'h0007);
        queue_tri(16'h0007, 16'h0008, 16'h0007);
        queue_tri(16'h00FF, 16'hFF00, 16'h8000);
        queue_tri(16'h8000, 16'h00FF, 16'hFF00);
        wait_drained();

        write_base('0);
        run_random(600);

        send_idle_pct = 76;
        recv_idle_pct = 11;
        write_base(CNT_W'(65520));
        run_random(550);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_base(CNT_W'(65536));
        run_random(250);

        write_base(CNT_W'($urandom_range(65000, 100)));
        run_random(350);

        repeat (10) @(negedge i_clk);
        if (!failed && expected_tris.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
